@@ src/slcr_pkg.sv @@
`timescale 1ns / 1ps

package slcr_pkg;

	// Default geometry of the line ring.
	localparam int LINE_SLOTS_DEF = 16;
	localparam int LINE_BYTES_DEF = 48;

	// Command codes on the request side.
	localparam logic [2:0] CMD_RX_BYTE      = 3'd0;
	localparam logic [2:0] CMD_SCROLL_OLDER = 3'd1;
	localparam logic [2:0] CMD_SCROLL_RESET = 3'd2;
	localparam logic [2:0] CMD_READ_CHAR    = 3'd3;
	localparam logic [2:0] CMD_CLEAR_ALL    = 3'd4;

	// Line terminators.
	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_CR = 8'd13;

	// Operation as classified by the front end.
	typedef enum logic [2:0] {
		OP_BYTE,
		OP_TERM,
		OP_SCROLL_UP,
		OP_SCROLL_RST,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] rx_byte;
		logic [3:0] line_offset;
		logic [5:0] column;
	} request_t;

	typedef struct packed {
		logic [7:0]  read_char;
		logic [4:0]  line_count;
		logic [3:0]  scroll_offset;
		logic [31:0] received_total;
		logic        line_committed;
	} result_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] rx_byte;
		logic [3:0] line_offset;
		logic [5:0] column;
	} op_item_t;

endpackage

@@ src/slcr_ram.sv @@
`timescale 1ns / 1ps

module slcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/slcr_front.sv @@
`timescale 1ns / 1ps

module slcr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  slcr_pkg::request_t  request,
	output logic                op_valid,
	output slcr_pkg::op_item_t  op_item,
	input  logic                op_take
);

	// Two-entry command queue; commands are classified on the way in.
	slcr_pkg::op_item_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_push;
	logic               do_pop;
	slcr_pkg::op_item_t classified;

	always_comb begin
		classified.rx_byte     = request.rx_byte;
		classified.line_offset = request.line_offset;
		classified.column      = request.column;
		unique case (request.command)
			slcr_pkg::CMD_RX_BYTE: begin
				if (request.rx_byte == slcr_pkg::CHAR_LF ||
						request.rx_byte == slcr_pkg::CHAR_CR) begin
					classified.op = slcr_pkg::OP_TERM;
				end else begin
					classified.op = slcr_pkg::OP_BYTE;
				end
			end
			slcr_pkg::CMD_SCROLL_OLDER: classified.op = slcr_pkg::OP_SCROLL_UP;
			slcr_pkg::CMD_SCROLL_RESET: classified.op = slcr_pkg::OP_SCROLL_RST;
			slcr_pkg::CMD_READ_CHAR:    classified.op = slcr_pkg::OP_READ;
			slcr_pkg::CMD_CLEAR_ALL:    classified.op = slcr_pkg::OP_CLEAR;
			default:                    classified.op = slcr_pkg::OP_NOP;
		endcase
	end

	assign full     = (count_q == 2'd2);
	assign op_valid = (count_q != 2'd0);
	assign op_item  = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = op_take && op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

endmodule

@@ src/slcr_back.sv @@
`timescale 1ns / 1ps

module slcr_back #(
	parameter int LINE_SLOTS = slcr_pkg::LINE_SLOTS_DEF,
	parameter int LINE_BYTES = slcr_pkg::LINE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	input  slcr_pkg::op_item_t op_item,
	output logic               op_take,
	output logic               empty,
	input  logic               pop,
	output slcr_pkg::result_t  result
);

	localparam int SLOT_W = $clog2(LINE_SLOTS);
	localparam int VL_W   = $clog2(LINE_SLOTS + 1);
	localparam int COL_W  = $clog2(LINE_BYTES);
	localparam int SUM_W  = ((VL_W > 4) ? VL_W : 4) + 2;

	localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(LINE_BYTES - 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(LINE_SLOTS - 1);
	localparam logic [VL_W-1:0]   FULL_LINES = VL_W'(LINE_SLOTS);
	localparam logic [SUM_W-1:0]  SLOTS_S    = SUM_W'(LINE_SLOTS);
	localparam logic [SUM_W-1:0]  SLOTS_M1_S = SUM_W'(LINE_SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_FIN,
		ST_READ
	} state_t;

	state_t            state_q, state_d;
	logic [COL_W-1:0]  asm_len_q, asm_len_d;
	logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
	logic [VL_W-1:0]   valid_lines_q, valid_lines_d;
	logic [SLOT_W-1:0] scroll_q, scroll_d;
	logic [31:0]       byte_cnt_q, byte_cnt_d;
	logic [COL_W-1:0]  cnt_q, cnt_d;
	logic              hit_q, hit_d;
	logic              out_valid_q, out_valid_d;
	slcr_pkg::result_t result_q, result_d;

	// Copy pipeline: read of the assembly buffer, then write of the line store.
	logic              copy_vld_s1;
	logic [COL_W-1:0]  col_s1;
	logic              keep_s1;

	logic              out_free;
	logic              emit;
	logic              commit_flag;
	logic [7:0]        char_d;
	logic [SUM_W-1:0]  back_sum;
	logic [SUM_W-1:0]  slot_sum;
	logic [SUM_W-1:0]  slot_fix;
	logic [SLOT_W-1:0] slot_rd;
	logic              col_ok;
	logic              read_hit;

	logic                    asm_we;
	logic [7:0]              asm_rdata;
	logic [SLOT_W+COL_W-1:0] line_waddr;
	logic [SLOT_W+COL_W-1:0] line_raddr;
	logic [7:0]              line_wdata;
	logic [7:0]              line_rdata;

	slcr_ram #(
		.WIDTH (8),
		.DEPTH (LINE_BYTES)
	) u_asm_ram (
		.clk     (clk),
		.wr_en   (asm_we),
		.wr_addr (asm_len_q),
		.wr_data (op_item.rx_byte),
		.rd_addr (cnt_q),
		.rd_data (asm_rdata)
	);

	slcr_ram #(
		.WIDTH (8),
		.DEPTH (LINE_SLOTS * (2 ** COL_W))
	) u_line_ram (
		.clk     (clk),
		.wr_en   (copy_vld_s1),
		.wr_addr (line_waddr),
		.wr_data (line_wdata),
		.rd_addr (line_raddr),
		.rd_data (line_rdata)
	);

	assign line_waddr = {wr_slot_q, col_s1};
	assign line_wdata = keep_s1 ? asm_rdata : 8'd0;

	// Newest-first line lookup, shifted by the scroll.
	assign back_sum = SUM_W'(op_item.line_offset) + SUM_W'(scroll_q);
	assign col_ok   = (9'(op_item.column) < 9'(LINE_BYTES));
	assign read_hit = (back_sum < SUM_W'(valid_lines_q)) && col_ok;
	assign slot_sum = SUM_W'(wr_slot_q) + SLOTS_M1_S - back_sum;
	assign slot_fix = (slot_sum >= SLOTS_S) ? (slot_sum - SLOTS_S) : slot_sum;
	assign slot_rd  = slot_fix[SLOT_W-1:0];
	assign line_raddr = {slot_rd, COL_W'(op_item.column)};

	assign out_free = !out_valid_q || pop;
	assign op_take  = (state_q == ST_IDLE) && op_valid && out_free;
	assign asm_we   = op_take && (op_item.op == slcr_pkg::OP_BYTE) && (asm_len_q < LAST_COL);

	always_comb begin
		state_d       = state_q;
		asm_len_d     = asm_len_q;
		wr_slot_d     = wr_slot_q;
		valid_lines_d = valid_lines_q;
		scroll_d      = scroll_q;
		byte_cnt_d    = byte_cnt_q;
		cnt_d         = cnt_q;
		hit_d         = hit_q;
		emit          = 1'b0;
		commit_flag   = 1'b0;
		char_d        = 8'd0;
		unique case (state_q)
			ST_IDLE: begin
				if (op_take) begin
					unique case (op_item.op)
						slcr_pkg::OP_BYTE: begin
							byte_cnt_d = byte_cnt_q + 32'd1;
							if (asm_len_q < LAST_COL) begin
								asm_len_d = asm_len_q + COL_W'(1);
							end
							emit = 1'b1;
						end
						slcr_pkg::OP_TERM: begin
							byte_cnt_d = byte_cnt_q + 32'd1;
							if (asm_len_q == '0) begin
								emit = 1'b1;
							end else begin
								cnt_d   = '0;
								state_d = ST_COPY;
							end
						end
						slcr_pkg::OP_SCROLL_UP: begin
							if (SUM_W'(scroll_q) + SUM_W'(1) < SUM_W'(valid_lines_q)) begin
								scroll_d = scroll_q + SLOT_W'(1);
							end
							emit = 1'b1;
						end
						slcr_pkg::OP_SCROLL_RST: begin
							scroll_d = '0;
							emit     = 1'b1;
						end
						slcr_pkg::OP_READ: begin
							hit_d   = read_hit;
							state_d = ST_READ;
						end
						slcr_pkg::OP_CLEAR: begin
							asm_len_d     = '0;
							wr_slot_d     = '0;
							valid_lines_d = '0;
							scroll_d      = '0;
							byte_cnt_d    = '0;
							emit          = 1'b1;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_COPY: begin
				cnt_d = cnt_q + COL_W'(1);
				if (cnt_q == LAST_COL) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				wr_slot_d = (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + SLOT_W'(1);
				if (valid_lines_q != FULL_LINES) begin
					valid_lines_d = valid_lines_q + VL_W'(1);
				end
				scroll_d    = '0;
				asm_len_d   = '0;
				commit_flag = 1'b1;
				emit        = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_READ: begin
				char_d  = hit_q ? line_rdata : 8'd0;
				emit    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		result_d.read_char      = char_d;
		result_d.line_count     = 5'(valid_lines_d);
		result_d.scroll_offset  = 4'(scroll_d);
		result_d.received_total = byte_cnt_d;
		result_d.line_committed = commit_flag;

		if (emit) begin
			out_valid_d = 1'b1;
		end else if (pop) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			asm_len_q     <= '0;
			wr_slot_q     <= '0;
			valid_lines_q <= '0;
			scroll_q      <= '0;
			byte_cnt_q    <= '0;
			cnt_q         <= '0;
			hit_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			copy_vld_s1   <= 1'b0;
			col_s1        <= '0;
			keep_s1       <= 1'b0;
			result_q      <= '0;
		end else begin
			state_q       <= state_d;
			asm_len_q     <= asm_len_d;
			wr_slot_q     <= wr_slot_d;
			valid_lines_q <= valid_lines_d;
			scroll_q      <= scroll_d;
			byte_cnt_q    <= byte_cnt_d;
			cnt_q         <= cnt_d;
			hit_q         <= hit_d;
			out_valid_q   <= out_valid_d;
			copy_vld_s1   <= (state_q == ST_COPY);
			col_s1        <= cnt_q;
			keep_s1       <= (cnt_q < asm_len_q);
			if (emit) begin
				result_q <= result_d;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

	// The ring never reports more lines than it has slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_lines_q <= FULL_LINES)
		else $error("line count exceeds ring size");

	// The scroll stays inside the stored lines, or at zero when there are none.
	assert property (@(posedge clk) disable iff (!arst_n)
		(SUM_W'(scroll_q) < SUM_W'(valid_lines_q)) || (scroll_q == '0))
		else $error("scroll offset outside stored lines");

	// A copy into the ring only runs for a line that holds bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> (asm_len_q != '0))
		else $error("empty line being committed");

	// A deferred result always finds the output register free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN || state_q == ST_READ) |-> !out_valid_q)
		else $error("deferred result would overwrite a waiting result");

endmodule

@@ src/serial_line_capture_ring.sv @@
`timescale 1ns / 1ps

// Serial line capture ring. Received bytes (command 0) are gathered into a
// line; CR or LF ends a non-empty line, which is then copied, zero-padded to
// LINE_BYTES, into a ring of LINE_SLOTS lines that overwrites the oldest one
// and returns the scroll to the newest line. Bytes beyond LINE_BYTES-1 in a
// line are dropped, and terminators are counted but never stored. Commands
// 1 and 2 step the scroll one line older or back to zero, command 3 reads
// one character of a line counted newest-first plus the scroll (0 past the
// stored lines or past the line width), and command 4 clears everything.
// Every command produces exactly one result that reports the state after it.
// Both sides look like queues: a command is transferred when push is high
// and full is low, a result when pop is high and empty is low. A front end
// classifies commands into a two-entry queue; the back end carries them out
// and holds one finished result in an output register, so up to two more
// commands are accepted while a result waits before full goes high. In the
// back end a byte, scroll, clear or unused command is done in the idle state,
// a read waits in a read state for the registered read of the line store,
// and a line end that commits a line goes through a copy state, copying
// the assembly buffer into the line store at one byte per cycle through its
// single write port, then a finish state. The line store needs no clearing
// pass after reset: only lines committed since the last reset or clear are
// ever read, and each commit rewrites every readable column of its slot.
module serial_line_capture_ring #(
	parameter int LINE_SLOTS = slcr_pkg::LINE_SLOTS_DEF,
	parameter int LINE_BYTES = slcr_pkg::LINE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  slcr_pkg::request_t request,
	output logic               empty,
	input  logic               pop,
	output slcr_pkg::result_t  result
);

	logic               op_valid;
	logic               op_take;
	slcr_pkg::op_item_t op_item;

	// Front end: accepts and classifies commands.
	slcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.op_valid (op_valid),
		.op_item  (op_item),
		.op_take  (op_take)
	);

	// Back end: holds the line state and storage and produces the results.
	slcr_back #(
		.LINE_SLOTS (LINE_SLOTS),
		.LINE_BYTES (LINE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_item  (op_item),
		.op_take  (op_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
